/* rtl/three_digit_segment_display_feeder_unit_macros.svh */
// assertion macros shared by the display feeder modules
`ifndef THREE_DIGIT_SEGMENT_DISPLAY_FEEDER_UNIT_MACROS_SVH
`define THREE_DIGIT_SEGMENT_DISPLAY_FEEDER_UNIT_MACROS_SVH

// same-cycle implication, clocked by clk, off during reset
`define TDSDF_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by clk, off during reset
`define TDSDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tdsdf_pkg.sv */
// types, constants and the segment table for the display feeder
package tdsdf_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DATA    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONTROL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_POINT   = 3'd4;

    localparam logic [7:0] MODE_RESET    = 8'h06;
    localparam logic [7:0] DATA_RESET    = 8'h40;
    localparam logic [7:0] ADDRESS_RESET = 8'hCD;
    localparam logic [7:0] CONTROL_RESET = 8'h8F;
    localparam logic       POINT_RESET   = 1'b1;

    localparam logic [7:0] POINT_BIT = 8'h80;

    // x / 10 == (x * RECIP10) >> RECIP_SHIFT for any 16-bit x
    localparam logic [16:0] RECIP10     = 17'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef struct packed {
        logic [7:0] mode_command;
        logic [7:0] data_command;
        logic [7:0] address_command;
        logic [7:0] control_command;
        logic       point_on_hundreds;
    } cfg_t;

    typedef struct packed {
        logic [7:0] units;
        logic [7:0] tens;
        logic [7:0] hundreds;
    } seg_set_t;

    typedef enum logic [2:0] {
        SEQ_MODE,
        SEQ_DATA,
        SEQ_ADDRESS,
        SEQ_UNITS,
        SEQ_TENS,
        SEQ_HUNDREDS,
        SEQ_CONTROL
    } seq_t;

    function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
        logic [7:0] pattern;
        case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

/* rtl/tdsdf_in_if.sv */
// input channel: one value to display per transaction
interface tdsdf_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] shown_value;

    modport source (output valid, output shown_value, input ready);
    modport sink (input valid, input shown_value, output ready);
endinterface

/* rtl/tdsdf_out_if.sv */
// output channel: one driver byte per transaction
interface tdsdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] link_byte;
    logic       frame_start;
    logic       last;

    modport source (output valid, output link_byte, output frame_start, output last,
                    input ready);
    modport sink (input valid, input link_byte, input frame_start, input last,
                  output ready);
endinterface

/* rtl/three_digit_segment_display_feeder_unit.sv */
// top level of the three-digit segment display feeder
//
// feed (sink): one shown_value per transaction; the low three decimal digits
// are shown. link (source): seven transactions per value, in order mode
// command, data command, address command, units, tens and hundreds segment
// bytes, control command. frame_start marks the four command bytes, last
// marks the control byte. the register port (wr_en, wr_index, wr_data) sets
// the four command bytes and the hundreds decimal point.
// the front splits off one digit per cycle through a shared reciprocal
// multiplier and can take a new value as it pushes the set of the last one;
// the back emits one byte per cycle while the receiver is ready and loads
// the next set as it registers the control byte of the previous one. the front
// keeps accepting while the queue (QUEUE_DEPTH sets) has room.
// reset empties front, queue and output register and loads the command
// registers with their defaults. when the receiver stalls the output byte
// holds, the back stops, and the queue then the front fill before feed.ready
// drops.
module three_digit_segment_display_feeder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tdsdf_in_if.sink                           feed,
    tdsdf_out_if.source                        link,
    input  logic                               wr_en,
    input  logic [tdsdf_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [tdsdf_pkg::CFG_DATA_W-1:0]   wr_data
);
    import tdsdf_pkg::*;

    cfg_t     cfg_reg;
    logic     push_valid;
    logic     push_ready;
    seg_set_t push_data;
    logic     pop_valid;
    logic     pop;
    seg_set_t pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode_command      <= MODE_RESET;
            cfg_reg.data_command      <= DATA_RESET;
            cfg_reg.address_command   <= ADDRESS_RESET;
            cfg_reg.control_command   <= CONTROL_RESET;
            cfg_reg.point_on_hundreds <= POINT_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_MODE:    cfg_reg.mode_command      <= wr_data;
                REG_DATA:    cfg_reg.data_command      <= wr_data;
                REG_ADDRESS: cfg_reg.address_command   <= wr_data;
                REG_CONTROL: cfg_reg.control_command   <= wr_data;
                REG_POINT:   cfg_reg.point_on_hundreds <= wr_data[0];
                default:     cfg_reg <= cfg_reg;
            endcase
        end
    end

    tdsdf_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .feed              (feed),
        .point_on_hundreds (cfg_reg.point_on_hundreds),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_data         (push_data)
    );

    tdsdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    tdsdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_data  (pop_data),
        .link      (link)
    );

endmodule

/* rtl/tdsdf_front.sv */
// front end: accepts values, splits off three decimal digits, maps them to segments
`include "three_digit_segment_display_feeder_unit_macros.svh"

module tdsdf_front (
    input  logic                clk,
    input  logic                rst_n,
    tdsdf_in_if.sink            feed,
    input  logic                point_on_hundreds,
    output logic                push_valid,
    input  logic                push_ready,
    output tdsdf_pkg::seg_set_t push_data
);
    import tdsdf_pkg::*;

    localparam logic [1:0] LAST_STEP = 2'd2;

    logic        busy_reg, busy_next;
    logic [1:0]  step_reg, step_next;
    logic [15:0] rem_reg, rem_next;
    logic [3:0]  units_reg, units_next;
    logic [3:0]  tens_reg, tens_next;

    logic [32:0] prod;
    logic [12:0] quot;
    logic [15:0] quot_x10;
    logic [15:0] rem_diff;
    logic [3:0]  digit;
    logic        last_step;
    logic        accept;

    // one digit per cycle through a reciprocal multiply
    assign prod     = {17'b0, rem_reg} * {16'b0, RECIP10};
    assign quot     = prod[RECIP_SHIFT+12:RECIP_SHIFT];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem_diff = rem_reg - quot_x10;
    assign digit    = rem_diff[3:0];

    assign last_step  = busy_reg && (step_reg == LAST_STEP);
    assign push_valid = last_step;
    assign feed.ready = !busy_reg || (last_step && push_ready);
    assign accept     = feed.valid && feed.ready;

    always_comb
    begin
        push_data.units    = seg_lookup(units_reg);
        push_data.tens     = seg_lookup(tens_reg);
        push_data.hundreds = seg_lookup(digit) | (point_on_hundreds ? POINT_BIT : 8'h00);
    end

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        units_next = units_reg;
        tens_next  = tens_reg;
        if (busy_reg && !last_step)
        begin
            step_next = step_reg + 2'd1;
            rem_next  = {3'b000, quot};
            if (step_reg == 2'd0)
            begin
                units_next = digit;
            end
            else
            begin
                tens_next = digit;
            end
        end
        else if (last_step && push_ready)
        begin
            busy_next = 1'b0;
            step_next = 2'd0;
        end
        if (accept)
        begin
            busy_next = 1'b1;
            step_next = 2'd0;
            rem_next  = feed.shown_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        units_reg <= units_next;
        tens_reg  <= tens_next;
    end

    `TDSDF_ASSERT_NEXT(a_accept_starts, feed.valid && feed.ready, busy_reg && step_reg == 2'd0, "front did not start on accepted value")
    `TDSDF_ASSERT(a_idle_step, !busy_reg, step_reg == 2'd0, "front step counter not cleared while idle")

endmodule

/* rtl/tdsdf_queue.sv */
// short fifo of segment sets between front and back
`include "three_digit_segment_display_feeder_unit_macros.svh"

module tdsdf_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  tdsdf_pkg::seg_set_t push_data,
    output logic                pop_valid,
    input  logic                pop,
    output tdsdf_pkg::seg_set_t pop_data
);
    import tdsdf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    seg_set_t        entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = count_reg < CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `TDSDF_ASSERT(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "queue count beyond depth")

endmodule

/* rtl/tdsdf_back.sv */
// back end: sequences the seven driver bytes per segment set into the output register
`include "three_digit_segment_display_feeder_unit_macros.svh"

module tdsdf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tdsdf_pkg::cfg_t     cfg,
    input  logic                pop_valid,
    output logic                pop,
    input  tdsdf_pkg::seg_set_t pop_data,
    tdsdf_out_if.source         link
);
    import tdsdf_pkg::*;

    seq_t       state_reg, state_next;
    logic       active_reg, active_next;
    seg_set_t   set_reg, set_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       frame_start_reg;
    logic       last_reg;

    logic       can_load;
    logic [7:0] emit_byte;
    logic       emit_start;
    logic       emit_last;

    assign can_load = !out_valid_reg || link.ready;
    assign pop = pop_valid &&
                 (!active_reg || (can_load && state_reg == SEQ_CONTROL));

    // next state
    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        set_next    = set_reg;
        if (pop)
        begin
            state_next  = SEQ_MODE;
            active_next = 1'b1;
            set_next    = pop_data;
        end
        else if (active_reg && can_load)
        begin
            case (state_reg)
                SEQ_MODE:     state_next = SEQ_DATA;
                SEQ_DATA:     state_next = SEQ_ADDRESS;
                SEQ_ADDRESS:  state_next = SEQ_UNITS;
                SEQ_UNITS:    state_next = SEQ_TENS;
                SEQ_TENS:     state_next = SEQ_HUNDREDS;
                SEQ_HUNDREDS: state_next = SEQ_CONTROL;
                SEQ_CONTROL:
                begin
                    state_next  = SEQ_MODE;
                    active_next = 1'b0;
                end
                default:      state_next = SEQ_MODE;
            endcase
        end
    end

    // byte for the current step
    always_comb
    begin
        emit_byte  = 8'h00;
        emit_start = 1'b0;
        emit_last  = 1'b0;
        case (state_reg)
            SEQ_MODE:
            begin
                emit_byte  = cfg.mode_command;
                emit_start = 1'b1;
            end
            SEQ_DATA:
            begin
                emit_byte  = cfg.data_command;
                emit_start = 1'b1;
            end
            SEQ_ADDRESS:
            begin
                emit_byte  = cfg.address_command;
                emit_start = 1'b1;
            end
            SEQ_UNITS:    emit_byte = set_reg.units;
            SEQ_TENS:     emit_byte = set_reg.tens;
            SEQ_HUNDREDS: emit_byte = set_reg.hundreds;
            SEQ_CONTROL:
            begin
                emit_byte  = cfg.control_command;
                emit_start = 1'b1;
                emit_last  = 1'b1;
            end
            default:
            begin
                emit_byte  = 8'h00;
                emit_start = 1'b0;
                emit_last  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_MODE;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            if (can_load)
            begin
                out_valid_reg <= active_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        if (can_load && active_reg)
        begin
            byte_reg        <= emit_byte;
            frame_start_reg <= emit_start;
            last_reg        <= emit_last;
        end
    end

    assign link.valid       = out_valid_reg;
    assign link.link_byte   = byte_reg;
    assign link.frame_start = frame_start_reg;
    assign link.last        = last_reg;

    `TDSDF_ASSERT(a_last_has_frame, out_valid_reg && last_reg, frame_start_reg, "last byte without strobe frame")
    `TDSDF_ASSERT_NEXT(a_drain, active_reg && state_reg == SEQ_CONTROL && can_load && !pop_valid, !active_reg, "sequencer did not go idle after control byte")

endmodule

/* tb/tb_three_digit_segment_display_feeder_unit.sv */
// self-checking testbench for the three-digit segment display feeder
module tb_three_digit_segment_display_feeder_unit;
    import tdsdf_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;

    // segment patterns for digits 9 down to 0, digit d at bits [8*d +: 8]
    localparam logic [79:0] SEG_PATTERNS = {
        8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
    };

    typedef struct packed {
        logic [7:0] link_byte;
        logic       frame_start;
        logic       last;
    } link_beat_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    tdsdf_in_if  feed_if ();
    tdsdf_out_if link_if ();

    three_digit_segment_display_feeder_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (feed_if),
        .link     (link_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    cfg_t        display_cfg;
    logic [15:0] values_to_show [$];
    link_beat_t  expected_beats [$];
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          feed_taken;
    int          fail_count;
    int          stall_cycles;

    function automatic logic [7:0] digit_pattern(int digit);
        return SEG_PATTERNS[digit*8 +: 8];
    endfunction

    // seven link bytes for one shown value
    function void predict_frames(logic [15:0] value);
        int         units;
        int         tens;
        int         hundreds;
        logic [7:0] top_byte;
        units    = value % 10;
        tens     = (value / 10) % 10;
        hundreds = (value / 100) % 10;
        top_byte = digit_pattern(hundreds);
        if (display_cfg.point_on_hundreds)
            top_byte = top_byte | POINT_BIT;
        expected_beats.push_back({display_cfg.mode_command, 1'b1, 1'b0});
        expected_beats.push_back({display_cfg.data_command, 1'b1, 1'b0});
        expected_beats.push_back({display_cfg.address_command, 1'b1, 1'b0});
        expected_beats.push_back({digit_pattern(units), 1'b0, 1'b0});
        expected_beats.push_back({digit_pattern(tens), 1'b0, 1'b0});
        expected_beats.push_back({top_byte, 1'b0, 1'b0});
        expected_beats.push_back({display_cfg.control_command, 1'b1, 1'b1});
    endfunction

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MODE:    display_cfg.mode_command      = data;
            REG_DATA:    display_cfg.data_command      = data;
            REG_ADDRESS: display_cfg.address_command   = data;
            REG_CONTROL: display_cfg.control_command   = data;
            REG_POINT:   display_cfg.point_on_hundreds = data[0];
            default:     ;
        endcase
    endtask

    task automatic program_registers(logic [7:0] mode_byte, logic [7:0] data_byte,
                                     logic [7:0] addr_byte, logic [7:0] ctrl_byte,
                                     logic [7:0] point_data);
        write_register(REG_MODE, mode_byte);
        write_register(REG_DATA, data_byte);
        write_register(REG_ADDRESS, addr_byte);
        write_register(REG_CONTROL, ctrl_byte);
        write_register(REG_POINT, point_data);
        // indices past the register list are ignored
        for (int k = REG_POINT + 1; k < 2**CFG_INDEX_W; k++)
            write_register(k[CFG_INDEX_W-1:0], 8'($urandom_range(0, 255)));
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (values_to_show.size() != 0 || feed_if.valid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_random_values(int count);
        logic [15:0] value;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                value = 16'($urandom_range(0, 999));
            else
                value = 16'($urandom);
            values_to_show.push_back(value);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!feed_if.valid || feed_taken)
            begin
                feed_taken = 1'b0;
                if (values_to_show.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    feed_if.valid       <= 1'b1;
                    feed_if.shown_value <= values_to_show.pop_front();
                end
                else
                begin
                    feed_if.valid <= 1'b0;
                end
            end
            link_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        link_beat_t seen;
        link_beat_t want;
        bit         moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (feed_if.valid && feed_if.ready)
            begin
                predict_frames(feed_if.shown_value);
                feed_taken = 1'b1;
                moved      = 1'b1;
            end
            if (link_if.valid && link_if.ready)
            begin
                moved = 1'b1;
                seen  = {link_if.link_byte, link_if.frame_start, link_if.last};
                if (expected_beats.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: byte %h start %b last %b",
                                 seen.link_byte, seen.frame_start, seen.last);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (seen.link_byte !== want.link_byte
                        || seen.frame_start !== want.frame_start
                        || seen.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: byte %h/%h start %b/%b last %b/%b (exp/act)",
                                     want.link_byte, seen.link_byte, want.frame_start,
                                     seen.frame_start, want.last, seen.last);
                    end
                end
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("** three_digit_segment_display_feeder_unit: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        display_cfg         = {MODE_RESET, DATA_RESET, ADDRESS_RESET, CONTROL_RESET, POINT_RESET};
        feed_if.valid       = 1'b0;
        feed_if.shown_value = '0;
        link_if.ready       = 1'b0;
        wr_en               = 1'b0;
        wr_index            = '0;
        wr_data             = '0;
        feed_taken          = 1'b0;
        fail_count          = 0;
        stall_cycles        = 0;
        send_idle_pct       = 29;
        recv_idle_pct       = 86;
        rst_n               = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults, digit extremes and values past 999
        values_to_show = {16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd101, 16'd999,
                          16'd1000, 16'd1009, 16'd9999, 16'd10000, 16'd65535, 16'd65000,
                          16'd123, 16'd456, 16'd789, 16'd808, 16'd32768, 16'd43690,
                          16'd21845, 16'd4321, 16'd5670};
        drain();

        program_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        queue_random_values(70);
        drain();

        send_idle_pct = 86;
        recv_idle_pct = 29;
        program_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_random_values(80);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // point register takes only bit 0 of the write data
        program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hFE);
        queue_random_values(80);
        drain();

        fail_count += expected_beats.size();
        if (fail_count == 0)
            $display("** three_digit_segment_display_feeder_unit: PASSED **");
        else
            $display("** three_digit_segment_display_feeder_unit: FAILED **");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tdsdf_pkg.sv
rtl/tdsdf_in_if.sv
rtl/tdsdf_out_if.sv
rtl/tdsdf_front.sv
rtl/tdsdf_queue.sv
rtl/tdsdf_back.sv
rtl/three_digit_segment_display_feeder_unit.sv
tb/tb_three_digit_segment_display_feeder_unit.sv
